// File: rtl/core/ordered_list_table_engine_assert.svh
// assertion macros for the ordered list table engine
// used by files that check their own logic; needs clk and rst_n in scope
`ifndef ORDERED_LIST_TABLE_ENGINE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ENGINE_ASSERT_SVH

// generic form with explicit clock and reset
`define OLTE_ASSERT_ON(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (prop)) else $error(msg);

// usual form on the block clock and reset
`define OLTE_ASSERT(lbl, prop, msg) \
  `OLTE_ASSERT_ON(lbl, clk, rst_n, prop, msg)

`endif

// File: rtl/core/olte_pkg.sv
// shared types and constants for the ordered list table engine
// no dependencies
package olte_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int VALUE_W       = 32;
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_INSERT = 2'd1,
    FN_DELETE = 2'd2,
    FN_SEARCH = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // broadcast to every cell in the execute cycle
  typedef struct packed {
    logic                      exec;
    logic                      full;
    func_t                     func;
    logic signed [VALUE_W-1:0] value;
  } cell_ctl_t;

  // prefix flags rippling from head to tail
  typedef struct packed {
    logic match;
    logic greater;
  } chain_t;

endpackage

// File: rtl/core/olte_cell.sv
// one position of the ordered list: holds an entry, compares it with the operand
// and shifts towards head or tail; depends on olte_pkg
module olte_cell
  import olte_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                      clk,
  input  cell_ctl_t                 ctl,
  input  logic [CW-1:0]             count,
  input  logic signed [VALUE_W-1:0] left_entry,
  input  logic signed [VALUE_W-1:0] right_entry,
  input  chain_t                    chain_in,
  output chain_t                    chain_out,
  output logic signed [VALUE_W-1:0] entry
);

  logic signed [VALUE_W-1:0] entry_r;
  logic signed [VALUE_W-1:0] entry_nxt;
  logic                      occ;
  logic                      eq;
  logic                      gt;

  assign occ = (CW'(IDX) < count);
  assign eq  = occ && (entry_r == ctl.value);
  assign gt  = occ && (entry_r > ctl.value);

  assign chain_out.match   = chain_in.match | eq;
  assign chain_out.greater = chain_in.greater | gt;
  assign entry             = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.func)
      FN_APPEND: begin
        // free positions take the word; only the one at the tail counts
        if (!ctl.full && !occ) begin
          entry_nxt = ctl.value;
        end
      end
      FN_INSERT: begin
        if (!ctl.full) begin
          if (chain_in.greater) begin
            entry_nxt = left_entry;
          end else if (gt || !occ) begin
            entry_nxt = ctl.value;
          end
        end
      end
      FN_DELETE: begin
        if (chain_in.match || eq) begin
          entry_nxt = right_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// File: rtl/core/ordered_list_table_engine.sv
// ordered list table engine: a word is taken when start is high and busy low,
// busy stays high for one execute cycle, and the result strobe follows in the cycle after it
// no new word is taken while busy is high; the limit is the compare and prefix ripple
// through the row of cells in the execute cycle; the result cannot be stalled
// synchronous active-low reset clears the count and control flags, entries stay unwritten
// top level of the row of olte_cell instances; depends on olte_pkg and the assert header
`include "ordered_list_table_engine_assert.svh"
module ordered_list_table_engine
  import olte_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_func,
  input  logic signed [VALUE_W-1:0]       in_value,
  output logic                            out_strobe,
  output logic [1:0]                      out_status,
  output logic                            out_found,
  output logic [ENTRY_COUNT_W-1:0]        out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                      busy_r;
  logic                      out_strobe_r;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  func_t                     func_r;
  logic signed [VALUE_W-1:0] value_r;
  status_t                   status_r;
  status_t                   status_nxt;
  logic                      found_r;
  logic                      full;
  logic                      found;
  cell_ctl_t                 ctl;

  logic signed [VALUE_W-1:0] entry  [DEPTH];
  chain_t                    chain  [DEPTH+1];

  assign full = (count_r == CW'(DEPTH));

  assign ctl.exec  = busy_r;
  assign ctl.full  = full;
  assign ctl.func  = func_r;
  assign ctl.value = value_r;

  assign chain[0] = '{match: 1'b0, greater: 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_e;
    logic signed [VALUE_W-1:0] right_e;
    if (i == 0) begin : g_head
      assign left_e = value_r;
    end else begin : g_mid
      assign left_e = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = entry[i];
    end else begin : g_body
      assign right_e = entry[i+1];
    end
    olte_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count_r),
      .left_entry  (left_e),
      .right_entry (right_e),
      .chain_in    (chain[i]),
      .chain_out   (chain[i+1]),
      .entry       (entry[i])
    );
  end

  assign found = chain[DEPTH].match;

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    unique case (func_r) inside
      FN_APPEND, FN_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      FN_DELETE: begin
        if (found) begin
          count_nxt = count_r - CW'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
        status_nxt = found ? ST_DONE : ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      count_r      <= '0;
    end else begin
      out_strobe_r <= busy_r;
      if (busy_r) begin
        busy_r  <= 1'b0;
        count_r <= count_nxt;
      end else if (start) begin
        busy_r <= 1'b1;
      end
    end
  end

  // operand and result words carry no reset
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      func_r  <= func_t'(in_func);
      value_r <= in_value;
    end
    if (busy_r) begin
      status_r <= status_nxt;
      found_r  <= found;
    end
  end

  assign busy            = busy_r;
  assign out_strobe      = out_strobe_r;
  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_entry_count = ENTRY_COUNT_W'(count_r);

  `OLTE_ASSERT(a_exec_gives_result, busy_r |=> out_strobe_r && !busy_r, "execute cycle without result")
  `OLTE_ASSERT(a_count_in_range, count_r <= CW'(DEPTH), "count beyond depth")
  `OLTE_ASSERT(a_full_only_when_full, out_strobe_r && status_r == ST_FULL |-> count_r == CW'(DEPTH), "full status with room left")
  `OLTE_ASSERT(a_not_found_flag, out_strobe_r && status_r == ST_NOT_FOUND |-> !found_r, "not found status with found set")

endmodule

// File: test/tb.sv
// testbench for ordered_list_table_engine: directed and random list operations,
// each result checked against an in-bench model of the ordered store
// depends on olte_pkg and the rtl top level
module tb;
  import olte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH     = DEPTH_DEF;
  localparam int RANDOM_WORDS   = 800;
  localparam int WATCHDOG_LIMIT = 200;
  localparam int TAIL_CYCLES    = 10;

  typedef struct {
    status_t                   status;
    logic                      found;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
  } list_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [1:0]                 in_func;
  logic signed [VALUE_W-1:0]  in_value;
  logic                       out_strobe;
  logic [1:0]                 out_status;
  logic                       out_found;
  logic [ENTRY_COUNT_W-1:0]   out_entry_count;

  // model of the stored sequence, head first
  logic signed [VALUE_W-1:0]  stored_values[$];
  list_result_t               pending_results[$];

  int error_count;
  int words_sent;
  int results_seen;
  int op_counts[4];
  int full_refusals;
  int misses;
  int max_fill;
  int idle_cycles;
  bit no_gaps;

  ordered_list_table_engine #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_entry_count (out_entry_count)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_func  = FN_APPEND;
    in_value = '0;
  end

  // applies one operation to the model and gives the result it must produce
  function automatic list_result_t apply_list_op(func_t f, logic signed [VALUE_W-1:0] v);
    list_result_t r;
    int hit;
    int pos;
    hit = -1;
    foreach (stored_values[i])
      if (hit < 0 && stored_values[i] == v) hit = i;
    r.found  = (hit >= 0);
    r.status = ST_DONE;
    case (f)
      FN_APPEND: begin
        if (stored_values.size() >= LIST_DEPTH) r.status = ST_FULL;
        else stored_values.push_back(v);
      end
      FN_INSERT: begin
        if (stored_values.size() >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // lands before the first greater value, so after any equal ones
          pos = stored_values.size();
          for (int i = stored_values.size() - 1; i >= 0; i--)
            if (stored_values[i] > v) pos = i;
          stored_values.insert(pos, v);
        end
      end
      FN_DELETE: begin
        if (hit < 0) r.status = ST_NOT_FOUND;
        else stored_values.delete(hit);
      end
      default: begin
        r.status = r.found ? ST_DONE : ST_NOT_FOUND;
      end
    endcase
    r.entry_count = ENTRY_COUNT_W'(stored_values.size());
    return r;
  endfunction

  task automatic send_word(func_t f, logic signed [VALUE_W-1:0] v);
    int gap;
    list_result_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    = 1'b1;
    in_func  = f;
    in_value = v;
    do @(posedge clk); while (busy);
    r = apply_list_op(f, v);
    pending_results.push_back(r);
    words_sent++;
    op_counts[f]++;
    if (r.status == ST_FULL) full_refusals++;
    if (r.status == ST_NOT_FOUND) misses++;
    if (stored_values.size() > max_fill) max_fill = stored_values.size();
  endtask

  // about four in ten values likely to collide, some from the store, the rest anything
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3) begin
      case ($urandom_range(0, 5))
        0: return {1'b1, {(VALUE_W-1){1'b0}}};
        1: return {1'b0, {(VALUE_W-1){1'b1}}};
        2: return '0;
        3: return '1;
        default: return VALUE_W'($signed($urandom_range(0, 15)) - 8);
      endcase
    end else if (sel <= 6 && stored_values.size() > 0) begin
      return stored_values[$urandom_range(0, stored_values.size() - 1)];
    end
    return $urandom;
  endfunction

  always @(posedge clk) begin
    list_result_t r;
    if (rst_n && out_strobe) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected: status %0d found %0d count %0d",
                 $time, out_status, out_found, out_entry_count);
        error_count++;
      end else begin
        r = pending_results.pop_front();
        if (out_status !== r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, r.status, out_status);
          error_count++;
        end
        if (out_found !== r.found) begin
          $display("%0t: found expected %0d actual %0d", $time, r.found, out_found);
          error_count++;
        end
        if (out_entry_count !== r.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, r.entry_count, out_entry_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_empty_store();
    send_word(FN_SEARCH, 32'sd0);
    send_word(FN_DELETE, {1'b1, {(VALUE_W-1){1'b0}}});
  endtask

  task automatic test_append_tail();
    send_word(FN_APPEND, {1'b1, {(VALUE_W-1){1'b0}}});
    send_word(FN_APPEND, {1'b0, {(VALUE_W-1){1'b1}}});
    // duplicate is still stored, found reports the earlier copy
    send_word(FN_APPEND, {1'b0, {(VALUE_W-1){1'b1}}});
  endtask

  task automatic test_sorted_insert();
    send_word(FN_INSERT, -32'sd1);
    send_word(FN_INSERT, 32'sd0);
    send_word(FN_INSERT, {1'b0, {(VALUE_W-1){1'b1}}});
    send_word(FN_INSERT, {1'b1, {(VALUE_W-1){1'b0}}});
  endtask

  task automatic test_search();
    send_word(FN_SEARCH, -32'sd1);
    send_word(FN_SEARCH, 32'sd12345);
  endtask

  task automatic test_delete_first_match();
    send_word(FN_DELETE, {1'b0, {(VALUE_W-1){1'b1}}});
    send_word(FN_DELETE, 32'sd777);
  endtask

  task automatic test_full_store();
    while (stored_values.size() < LIST_DEPTH)
      send_word(FN_INSERT, $urandom);
    send_word(FN_APPEND, 32'sd5);
    send_word(FN_INSERT, {1'b1, {(VALUE_W-1){1'b0}}});
  endtask

  task automatic test_random_mix();
    int sent;
    int phase_len;
    int bias;
    int roll;
    func_t f;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      // fill-heavy, drain-heavy or balanced stretches walk the count end to end
      phase_len = $urandom_range(20, 60);
      bias      = $urandom_range(0, 2);
      no_gaps   = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        case (bias)
          0: f = (roll < 40) ? FN_INSERT : (roll < 70) ? FN_APPEND :
                 (roll < 85) ? FN_SEARCH : FN_DELETE;
          1: f = (roll < 60) ? FN_DELETE : (roll < 80) ? FN_SEARCH :
                 (roll < 90) ? FN_INSERT : FN_APPEND;
          default: f = func_t'($urandom_range(0, 3));
        endcase
        send_word(f, pick_value());
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    error_count   = 0;
    words_sent    = 0;
    results_seen  = 0;
    full_refusals = 0;
    misses        = 0;
    max_fill      = 0;
    idle_cycles   = 0;
    no_gaps       = 1'b0;
    foreach (op_counts[i]) op_counts[i] = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_empty_store();
    test_append_tail();
    test_sorted_insert();
    test_search();
    test_delete_first_match();
    test_full_store();
    test_random_mix();

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d words sent (append %0d, insert %0d, delete %0d, search %0d), %0d results",
             words_sent, op_counts[FN_APPEND], op_counts[FN_INSERT], op_counts[FN_DELETE],
             op_counts[FN_SEARCH], results_seen);
    $display("full refusals %0d, not found %0d, highest fill %0d of %0d",
             full_refusals, misses, max_fill, LIST_DEPTH);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
